[hdl/knc_pkg.sv]
// Shared constants, register codes and the token type of the nearest-centroid engine.
package knc_pkg;

  // Sizes of the centroid store.
  localparam int MAX_DIMS     = 128;
  localparam int MAX_CLUSTERS = 128;
  localparam int COORD_BITS   = 16;

  // Port field widths.
  localparam int CLUSTER_IDX_W = 7;
  localparam int DIM_IDX_W     = 7;
  localparam int DIST_W        = 39;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  // Derived internal widths.
  localparam int ADDR_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int CCNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;

  // Largest partial distance; sums saturate here.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS     = 2'd0,
    REG_CLUSTERS = 2'd1
  } cfg_reg_e;

  // One item travelling down the row of centroid cells.
  typedef struct packed {
    logic                            valid;
    logic                            mode;
    logic                            wr_ok;
    logic [CLUSTER_IDX_W-1:0]        ci;
    logic [ADDR_W-1:0]               addr;
    logic signed [COORD_BITS-1:0]    x;
    logic                            last;
    logic [CLUSTER_IDX_W-1:0]        best_idx;
    logic [DIST_W-1:0]               best_d;
  } tok_t;

endpackage

[hdl/knc_if.sv]
// Channel interfaces of the nearest-centroid engine: items, results and configuration.
interface knc_item_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic [knc_pkg::CLUSTER_IDX_W-1:0]     cluster_index;
  logic [knc_pkg::DIM_IDX_W-1:0]         dim_index;
  logic signed [knc_pkg::COORD_BITS-1:0] coord_value;

  modport source (output valid, mode, cluster_index, dim_index, coord_value, input ready);
  modport sink (input valid, mode, cluster_index, dim_index, coord_value, output ready);
endinterface

interface knc_result_if;
  logic                              valid;
  logic                              ready;
  logic [knc_pkg::CLUSTER_IDX_W-1:0] nearest_cluster;
  logic [knc_pkg::DIST_W-1:0]        squared_distance;

  modport source (output valid, nearest_cluster, squared_distance, input ready);
  modport sink (input valid, nearest_cluster, squared_distance, output ready);
endinterface

interface knc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [knc_pkg::CFG_IDX_W-1:0]  index;
  logic [knc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/knc_cell.sv]
// One centroid cell: coordinate memory, squared difference and running distance sum.
module knc_cell #(
  parameter int CellIdx = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [knc_pkg::CCNT_W-1:0]  clus_eff_i,
  input  knc_pkg::tok_t               tok_i,
  output knc_pkg::tok_t               tok_o
);

  localparam bit IsFirst = (CellIdx == 0);

  logic signed [knc_pkg::COORD_BITS-1:0] mem [knc_pkg::MAX_DIMS];
  logic signed [knc_pkg::COORD_BITS-1:0] rd_q;
  knc_pkg::tok_t                         tok_a_q, tok_b_q, tok_q, tok_c;
  logic signed [knc_pkg::DIFF_W-1:0]     diff;
  logic signed [2*knc_pkg::DIFF_W-1:0]   prod;
  logic [knc_pkg::SQ_W-1:0]              sq_q;
  logic [knc_pkg::DIST_W-1:0]            sum_q, sum_d, s_sat;
  logic [knc_pkg::DIST_W:0]              s_full;
  logic                                  active, take, wr_en;

  assign active = (int'(clus_eff_i) > CellIdx);
  assign wr_en  = adv_i && tok_i.valid && !tok_i.mode && tok_i.wr_ok &&
                  (tok_i.ci == knc_pkg::CLUSTER_IDX_W'(CellIdx));

  // Stage A: write a centroid coordinate or read the one for the current dimension.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tok_i.addr] <= tok_i.x;
    end
    if (adv_i) begin
      rd_q <= mem[tok_i.addr];
    end
  end

  // Stage B: signed difference and its square.
  assign diff = {tok_a_q.x[knc_pkg::COORD_BITS-1], tok_a_q.x}
              - {rd_q[knc_pkg::COORD_BITS-1], rd_q};
  assign prod = diff * diff;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_q <= prod[knc_pkg::SQ_W-1:0];
    end
  end

  // Stage C: saturating accumulation and the running minimum at the end of a point.
  assign s_full = {1'b0, sum_q} + (knc_pkg::DIST_W + 1)'(sq_q);
  assign s_sat  = s_full[knc_pkg::DIST_W] ? knc_pkg::DIST_MAX : s_full[knc_pkg::DIST_W-1:0];
  assign take   = IsFirst || (active && (s_sat < tok_b_q.best_d));

  always_comb begin
    tok_c = tok_b_q;
    sum_d = sum_q;
    if (tok_b_q.valid && tok_b_q.mode) begin
      if (active) begin
        sum_d = s_sat;
      end
      if (tok_b_q.last) begin
        if (take) begin
          tok_c.best_idx = knc_pkg::CLUSTER_IDX_W'(CellIdx);
          tok_c.best_d   = s_sat;
        end
        sum_d = '0;
      end
    end
  end

  // Token pipeline and distance sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
      tok_q   <= '0;
      sum_q   <= '0;
    end else if (adv_i) begin
      tok_a_q <= tok_i;
      tok_b_q <= tok_a_q;
      tok_q   <= tok_c;
      sum_q   <= sum_d;
    end
  end

  assign tok_o = tok_q;

  // A centroid write never touches the distance sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && tok_b_q.valid && !tok_b_q.mode) |=> $stable(sum_q))
    else $error("centroid write changed a distance sum");

  // The sum is cleared once the last coordinate of a point has passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && tok_b_q.valid && tok_b_q.last) |=> (sum_q == '0))
    else $error("distance sum not cleared after end of point");

  // The best index handed on never names a cell further down the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_q.valid && tok_q.last) |-> (int'(tok_q.best_idx) <= CellIdx))
    else $error("best index points past this cell");

endmodule

[hdl/kmeans_nearest_centroid.sv]
// Top level of the k-means nearest-centroid engine: control, configuration and the cell row.
//
//   Channel    Dir   Beat contents
//   cfg_i      in    index, data (dims_in_use, clusters_in_use)
//   item_i     in    mode, cluster_index, dim_index, coord_value
//   result_o   out   nearest_cluster, squared_distance
//
// One item beat is accepted per clock cycle unless the row is stopped. Each item walks the
// row of MAX_CLUSTERS cells, passing through the memory read, square and accumulate
// stages of every cell, and a result is registered once a finished point leaves the row.
// Reset sets both registers to 128 and clears every distance sum at once; the centroid
// memories hold no defined value until written. The row stops only while a finished
// point sits at its end and the result register still holds an untaken beat.
module kmeans_nearest_centroid (
  input logic          clk_i,
  input logic          rst_ni,
  knc_cfg_if.sink      cfg_i,
  knc_item_if.sink     item_i,
  knc_result_if.source result_o
);

  logic [knc_pkg::CFG_DATA_W-1:0]    dims_q, dims_d, clus_q, clus_d;
  logic [knc_pkg::DCNT_W-1:0]        dims_eff;
  logic [knc_pkg::CCNT_W-1:0]        clus_eff;
  logic [knc_pkg::ADDR_W-1:0]        cnt_q, cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [knc_pkg::CLUSTER_IDX_W-1:0] out_idx_q;
  logic [knc_pkg::DIST_W-1:0]        out_dist_q;
  logic                              item_acc, pt_last, adv, load_out;
  knc_pkg::tok_t                     head, tail;
  knc_pkg::tok_t                     chain [0:knc_pkg::MAX_CLUSTERS];

  // Configuration writes; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    dims_d = dims_q;
    clus_d = clus_q;
    if (cfg_i.valid) begin
      case (knc_pkg::cfg_reg_e'(cfg_i.index))
        knc_pkg::REG_DIMS:     dims_d = cfg_i.data;
        knc_pkg::REG_CLUSTERS: clus_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // Register values limited to the supported range, zero acting as one.
  assign dims_eff = (dims_q == '0) ? knc_pkg::DCNT_W'(1) :
                    (int'(dims_q) > knc_pkg::MAX_DIMS) ? knc_pkg::DCNT_W'(knc_pkg::MAX_DIMS) :
                    knc_pkg::DCNT_W'(dims_q);
  assign clus_eff = (clus_q == '0) ? knc_pkg::CCNT_W'(1) :
                    (int'(clus_q) > knc_pkg::MAX_CLUSTERS) ?
                    knc_pkg::CCNT_W'(knc_pkg::MAX_CLUSTERS) : knc_pkg::CCNT_W'(clus_q);

  // The row advances unless a finished point cannot leave it.
  assign tail     = chain[knc_pkg::MAX_CLUSTERS];
  assign adv      = !(tail.valid && tail.last && out_valid_q && !result_o.ready);
  assign item_i.ready = adv;
  assign item_acc = item_i.valid && adv;
  assign pt_last  = (knc_pkg::DCNT_W'(cnt_q) + knc_pkg::DCNT_W'(1)) >= dims_eff;

  // Coordinate counter of the current point.
  always_comb begin
    cnt_d = cnt_q;
    if (item_acc && item_i.mode) begin
      cnt_d = pt_last ? '0 : cnt_q + knc_pkg::ADDR_W'(1);
    end
  end

  // Token entering the first cell.
  always_comb begin
    head          = '0;
    head.valid    = item_acc;
    head.mode     = item_i.mode;
    head.wr_ok    = (int'(item_i.dim_index) < knc_pkg::MAX_DIMS);
    head.ci       = item_i.cluster_index;
    head.addr     = item_i.mode ? cnt_q : knc_pkg::ADDR_W'(item_i.dim_index);
    head.x        = item_i.coord_value;
    head.last     = item_i.mode && pt_last;
  end

  assign chain[0] = head;

  // Row of centroid cells.
  for (genvar c = 0; c < knc_pkg::MAX_CLUSTERS; c++) begin : g_cell
    knc_cell #(
      .CellIdx (c)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .clus_eff_i (clus_eff),
      .tok_i      (chain[c]),
      .tok_o      (chain[c+1])
    );
  end

  // Result register.
  assign load_out = adv && tail.valid && tail.last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q  <= tail.best_idx;
      out_dist_q <= tail.best_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q      <= knc_pkg::CFG_DATA_W'(128);
      clus_q      <= knc_pkg::CFG_DATA_W'(128);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dims_q      <= dims_d;
      clus_q      <= clus_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.nearest_cluster  = out_idx_q;
  assign result_o.squared_distance = out_dist_q;

  // The counter restarts after the last coordinate of a point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_acc && item_i.mode && pt_last) |=> (cnt_q == '0))
    else $error("coordinate counter not restarted");

  // A result only shows up after a finished point left the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(tail.valid && tail.last))
    else $error("result without a finished point");

  // Input is held off only while an untaken result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (out_valid_q && tail.valid && tail.last))
    else $error("input stalled without a waiting result");

endmodule

[tb/kmeans_nearest_centroid_tb.sv]
// Self-checking testbench for the k-means nearest-centroid engine with its own prediction.
`timescale 1ns / 100ps

module kmeans_nearest_centroid_tb;

  localparam int          CLK_PERIOD    = 8;
  localparam int          SETTLE_CYCLES = 3 * knc_pkg::MAX_CLUSTERS + 16;
  localparam int          RESULT_HOLD   = 1200;
  localparam int          RANDOM_ITEMS  = 520;
  localparam int          PRESSURE_PTS  = 420;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  localparam logic MODE_CENTROID = 1'b0;
  localparam logic MODE_POINT    = 1'b1;

  localparam logic signed [knc_pkg::COORD_BITS-1:0] COORD_MIN =
    {1'b1, {(knc_pkg::COORD_BITS-1){1'b0}}};
  localparam logic signed [knc_pkg::COORD_BITS-1:0] COORD_MAX =
    {1'b0, {(knc_pkg::COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic [knc_pkg::CLUSTER_IDX_W-1:0] cluster;
    logic [knc_pkg::DIST_W-1:0]        distance;
  } nearest_t;

  // Tracks centroids, registers and running sums, and queues the nearest centroid of
  // each finished point until the block reports it.
  class nearest_centroid_scoreboard;
    logic signed [knc_pkg::COORD_BITS-1:0]
      centroid_mem [knc_pkg::MAX_CLUSTERS][knc_pkg::MAX_DIMS];
    logic [knc_pkg::DIST_W-1:0]     dist_sum [knc_pkg::MAX_CLUSTERS];
    int unsigned                    coord_pos;
    logic [knc_pkg::CFG_DATA_W-1:0] dims_reg;
    logic [knc_pkg::CFG_DATA_W-1:0] clusters_reg;
    nearest_t                       pending_nearest [$];
    int unsigned                    errors;
    int unsigned                    checked;
    int unsigned                    points;

    function new();
      foreach (dist_sum[c]) dist_sum[c] = '0;
      coord_pos    = 0;
      dims_reg     = 8'd128;
      clusters_reg = 8'd128;
      errors       = 0;
      checked      = 0;
      points       = 0;
    endfunction

    function int unsigned pending();
      return pending_nearest.size();
    endfunction

    // A zero register acts as one; anything past the store size acts as the store size.
    function int unsigned clamp_size(logic [knc_pkg::CFG_DATA_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : int'(v);
    endfunction

    function void write_reg(knc_pkg::cfg_reg_e idx, logic [knc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        knc_pkg::REG_DIMS:     dims_reg = val;
        knc_pkg::REG_CLUSTERS: clusters_reg = val;
        default: ;
      endcase
    endfunction

    // Applies one accepted item beat; a finished point queues its nearest centroid.
    function void note_item(logic mode, logic [knc_pkg::CLUSTER_IDX_W-1:0] ci,
                            logic [knc_pkg::DIM_IDX_W-1:0] di,
                            logic signed [knc_pkg::COORD_BITS-1:0] x);
      int unsigned       n_dims;
      int unsigned       n_clus;
      int unsigned       pos;
      longint            diff;
      longint unsigned   mag;
      longint unsigned   total;
      nearest_t          best;

      if (mode == MODE_CENTROID) begin
        if (ci < knc_pkg::MAX_CLUSTERS && di < knc_pkg::MAX_DIMS) centroid_mem[ci][di] = x;
        return;
      end

      n_dims = clamp_size(dims_reg, knc_pkg::MAX_DIMS);
      n_clus = clamp_size(clusters_reg, knc_pkg::MAX_CLUSTERS);
      pos    = (coord_pos >= knc_pkg::MAX_DIMS) ? knc_pkg::MAX_DIMS - 1 : coord_pos;

      // Every active centroid accumulates its squared difference, saturating.
      for (int c = 0; c < n_clus; c++) begin
        diff  = longint'(x) - longint'(centroid_mem[c][pos]);
        mag   = (diff < 0) ? longint'(-diff) : longint'(diff);
        total = (mag >= (64'd1 << 20)) ? 64'(knc_pkg::DIST_MAX) : mag * mag;
        total = total + 64'(dist_sum[c]);
        dist_sum[c] = (total > 64'(knc_pkg::DIST_MAX)) ? knc_pkg::DIST_MAX :
                      total[knc_pkg::DIST_W-1:0];
      end

      if (coord_pos + 1 < n_dims) begin
        coord_pos++;
        return;
      end

      // Plain argmin; a strict compare keeps the lowest index on ties.
      best.cluster  = '0;
      best.distance = dist_sum[0];
      for (int c = 1; c < n_clus; c++) begin
        if (dist_sum[c] < best.distance) begin
          best.distance = dist_sum[c];
          best.cluster  = knc_pkg::CLUSTER_IDX_W'(c);
        end
      end
      pending_nearest.insert(pending_nearest.size(), best);
      points++;
      foreach (dist_sum[c]) dist_sum[c] = '0;
      coord_pos = 0;
    endfunction

    function void check_result(logic [knc_pkg::CLUSTER_IDX_W-1:0] cluster,
                               logic [knc_pkg::DIST_W-1:0] distance);
      nearest_t want;

      if (pending_nearest.size() == 0) begin
        $error("result beat with no point pending: nearest_cluster %0d, squared_distance %0d",
               cluster, distance);
        errors++;
        return;
      end
      want = pending_nearest.pop_front();
      checked++;
      if (cluster !== want.cluster) begin
        $error("nearest_cluster mismatch: expected %0d, actual %0d", want.cluster, cluster);
        errors++;
      end
      if (distance !== want.distance) begin
        $error("squared_distance mismatch: expected %0d, actual %0d", want.distance,
               distance);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  knc_cfg_if    cfg_ch ();
  knc_item_if   item_ch ();
  knc_result_if res_ch ();

  kmeans_nearest_centroid u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_ch),
    .item_i  (item_ch),
    .result_o(res_ch)
  );

  nearest_centroid_scoreboard sb;

  // Shadow of what the stimulus has written, so points only read loaded entries.
  logic signed [knc_pkg::COORD_BITS-1:0]
    cent_shadow [knc_pkg::MAX_CLUSTERS][knc_pkg::MAX_DIMS];
  bit cent_loaded [knc_pkg::MAX_CLUSTERS][knc_pkg::MAX_DIMS];

  bit          item_burst;
  bit          result_burst;
  bit          hold_results;
  int unsigned items_sent;
  int unsigned centroid_writes;
  int unsigned shape_changes;
  int unsigned cycle_count = 0;

  // Free-running clock.
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Cycle counter and timeout.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  // Monitors: every accepted beat is fed to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(knc_pkg::cfg_reg_e'(cfg_ch.index), cfg_ch.data);
      if (item_ch.valid && item_ch.ready)
        sb.note_item(item_ch.mode, item_ch.cluster_index, item_ch.dim_index,
                     item_ch.coord_value);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.nearest_cluster, res_ch.squared_distance);
    end
  end

  // Result side: a random stall before each beat, bursts without stalls, and one long hold.
  initial begin
    int unsigned stall;

    res_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (RESULT_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end
      if ($urandom_range(29) == 0) result_burst = ~result_burst;
      stall = result_burst ? 0 : $urandom_range(11);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Offers one item beat after a random gap and returns at the edge that accepts it.
  task automatic send_item(logic mode, logic [knc_pkg::CLUSTER_IDX_W-1:0] ci,
                           logic [knc_pkg::DIM_IDX_W-1:0] di,
                           logic signed [knc_pkg::COORD_BITS-1:0] x);
    int unsigned gap;

    gap = item_burst ? 0 : $urandom_range(11);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.mode          <= mode;
    item_ch.cluster_index <= ci;
    item_ch.dim_index     <= di;
    item_ch.coord_value   <= x;
    if (mode == MODE_CENTROID) begin
      cent_shadow[ci][di] = x;
      cent_loaded[ci][di] = 1'b1;
      centroid_writes++;
    end
    items_sent++;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic write_centroid(int c, int d, logic signed [knc_pkg::COORD_BITS-1:0] x);
    send_item(MODE_CENTROID, knc_pkg::CLUSTER_IDX_W'(c), knc_pkg::DIM_IDX_W'(d), x);
  endtask

  // Extremes, small values near zero, or anything at all.
  function automatic logic signed [knc_pkg::COORD_BITS-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3:    return knc_pkg::COORD_BITS'(int'($urandom_range(64)) - 32);
      default: return knc_pkg::COORD_BITS'($urandom);
    endcase
  endfunction

  // Writes the centroid block in use; without refresh only entries never loaded.
  task automatic load_centroids(int n_clus, int n_dims, bit refresh);
    for (int c = 0; c < n_clus; c++)
      for (int d = 0; d < n_dims; d++)
        if (refresh || !cent_loaded[c][d]) write_centroid(c, d, rand_coord());
  endtask

  // One data point: either close to a random centroid or fully random, optionally
  // with stray centroid writes mixed in between its coordinates.
  task automatic send_point(int n_clus, int n_dims, bit stray);
    int                                    target;
    bit                                    near;
    logic signed [knc_pkg::COORD_BITS-1:0] x;

    target = $urandom_range(n_clus - 1);
    near   = ($urandom_range(2) != 0);
    for (int d = 0; d < n_dims; d++) begin
      if (stray && $urandom_range(15) == 0)
        write_centroid($urandom_range(knc_pkg::MAX_CLUSTERS - 1),
                       $urandom_range(knc_pkg::MAX_DIMS - 1), rand_coord());
      if (near)
        x = knc_pkg::COORD_BITS'(int'(cent_shadow[target][d]) +
                                 int'($urandom_range(6)) - 3);
      else
        x = rand_coord();
      send_item(MODE_POINT, knc_pkg::CLUSTER_IDX_W'($urandom),
                knc_pkg::DIM_IDX_W'($urandom), x);
    end
  endtask

  // Both registers back to back; valid stays high between the two beats.
  task automatic set_shape(logic [knc_pkg::CFG_DATA_W-1:0] dims_val,
                           logic [knc_pkg::CFG_DATA_W-1:0] clus_val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= knc_pkg::REG_DIMS;
    cfg_ch.data  <= dims_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= knc_pkg::REG_CLUSTERS;
    cfg_ch.data  <= clus_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shape_changes++;
  endtask

  // Stops offering items, waits for every pending result, then lets the row empty.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    int                             phase;
    int                             n_dims;
    int                             n_clus;
    int                             n_points;
    int unsigned                    start_items;
    logic [knc_pkg::CFG_DATA_W-1:0] dims_val;
    logic [knc_pkg::CFG_DATA_W-1:0] clus_val;

    sb = new();
    rst_n                 = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = knc_pkg::REG_DIMS;
    cfg_ch.data           = '0;
    item_ch.valid         = 1'b0;
    item_ch.mode          = MODE_CENTROID;
    item_ch.cluster_index = '0;
    item_ch.dim_index     = '0;
    item_ch.coord_value   = '0;
    item_burst            = 1'b0;
    result_burst          = 1'b0;
    hold_results          = 1'b0;
    items_sent            = 0;
    centroid_writes       = 0;
    shape_changes         = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero registers act as one coordinate and one centroid; extreme distances.
    set_shape(8'd0, 8'd0);
    write_centroid(0, 0, COORD_MIN);
    send_item(MODE_POINT, 7'h7f, 7'h7f, COORD_MAX);
    send_item(MODE_POINT, 7'h00, 7'h00, COORD_MIN);
    drain();

    // Centroids 1 and 2 are equal, so a point on them ties and picks index 1.
    set_shape(8'd2, 8'd3);
    write_centroid(0, 0, 16'sd0);
    write_centroid(0, 1, 16'sd0);
    write_centroid(1, 0, 16'sd10);
    write_centroid(1, 1, -16'sd10);
    write_centroid(2, 0, 16'sd10);
    write_centroid(2, 1, -16'sd10);
    send_item(MODE_POINT, 7'h00, 7'h7f, 16'sd10);
    send_item(MODE_POINT, 7'h7f, 7'h00, -16'sd10);
    send_item(MODE_POINT, 7'h55, 7'h2a, 16'sd0);
    send_item(MODE_POINT, 7'h2a, 7'h55, 16'sd0);
    drain();

    // A centroid write inside a point, then dims shrunk below the coordinate count,
    // so the very next coordinate closes the point.
    set_shape(8'd6, 8'd2);
    load_centroids(2, 6, 1'b1);
    send_point(2, 4, 1'b0);
    write_centroid(1, 4, 16'sd100);
    drain();
    set_shape(8'd3, 8'd2);
    send_item(MODE_POINT, 7'h11, 7'h22, 16'sd97);
    drain();

    // Largest distance: all 128 coordinates at opposite extremes, two tied centroids.
    set_shape(8'd255, 8'd2);
    for (int c = 0; c < 2; c++)
      for (int d = 0; d < knc_pkg::MAX_DIMS; d++) write_centroid(c, d, COORD_MIN);
    for (int d = 0; d < knc_pkg::MAX_DIMS; d++)
      send_item(MODE_POINT, knc_pkg::CLUSTER_IDX_W'($urandom),
                knc_pkg::DIM_IDX_W'($urandom), COORD_MAX);
    repeat (2) send_point(2, knc_pkg::MAX_DIMS, 1'b0);
    drain();

    // Every centroid in play, register above range.
    set_shape(8'd2, 8'd200);
    load_centroids(knc_pkg::MAX_CLUSTERS, 2, 1'b1);
    repeat (8) send_point(knc_pkg::MAX_CLUSTERS, 2, 1'b1);

    // Random phases with random shapes and content.
    phase       = 0;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      drain();
      item_burst = ($urandom_range(3) == 0);
      if (phase == 0) begin
        // Results held back while single-coordinate points keep coming, so the row
        // fills up and the input stalls.
        n_clus = $urandom_range(1, 6);
        set_shape(8'd1, 8'(n_clus));
        load_centroids(n_clus, 1, 1'b0);
        item_burst   = 1'b1;
        hold_results = 1'b1;
        repeat (PRESSURE_PTS) send_point(n_clus, 1, 1'b0);
      end else begin
        case ($urandom_range(9))
          0: begin
            n_dims   = $urandom_range(1) ? knc_pkg::MAX_DIMS :
                       $urandom_range(64, knc_pkg::MAX_DIMS - 1);
            n_clus   = $urandom_range(1, 2);
            n_points = $urandom_range(2, 3);
          end
          1: begin
            n_dims   = $urandom_range(1, 2);
            n_clus   = $urandom_range(1) ? knc_pkg::MAX_CLUSTERS :
                       $urandom_range(64, knc_pkg::MAX_CLUSTERS - 1);
            n_points = $urandom_range(4, 8);
          end
          default: begin
            n_dims   = $urandom_range(1, 8);
            n_clus   = $urandom_range(1, 12);
            n_points = $urandom_range(4, 20);
          end
        endcase
        dims_val = 8'(n_dims);
        clus_val = 8'(n_clus);
        if (n_dims == 1 && $urandom_range(1)) dims_val = '0;
        if (n_clus == 1 && $urandom_range(1)) clus_val = '0;
        if (n_dims == knc_pkg::MAX_DIMS && $urandom_range(1))
          dims_val = 8'($urandom_range(knc_pkg::MAX_DIMS + 1, 255));
        if (n_clus == knc_pkg::MAX_CLUSTERS && $urandom_range(1))
          clus_val = 8'($urandom_range(knc_pkg::MAX_CLUSTERS + 1, 255));
        set_shape(dims_val, clus_val);
        load_centroids(n_clus, n_dims, $urandom_range(1));
        repeat (n_points) send_point(n_clus, n_dims, 1'b1);
      end
      phase++;
    end
    drain();

    $display("Run covered %0d item beats (%0d centroid writes) over %0d register settings,",
             items_sent, centroid_writes, shape_changes);
    $display("with %0d points predicted, %0d results compared and one long result stall.",
             sb.points, sb.checked);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/knc_pkg.sv
hdl/knc_if.sv
hdl/knc_cell.sv
hdl/kmeans_nearest_centroid.sv
tb/kmeans_nearest_centroid_tb.sv
